FILE: rtl/core/fsms_pkg.sv
// ----------------------------------------------------------------------------
// fsms_pkg: shared types and constants of the forward span monotonic stack
// Payload structs of both channels, the command passed from the front to the
// back, the stack entry, the queue status and the back state encoding.
// ----------------------------------------------------------------------------
package fsms_pkg;

	localparam int MAX_LEN_DEF     = 64;
	localparam int QUEUE_DEPTH_DEF = 2;
	localparam int VAL_W           = 32;
	localparam int IDX_W           = 6;
	localparam int POS_W           = 7;

	typedef struct packed {
		logic signed [VAL_W-1:0] sample_value;
		logic                    last_sample;
	} in_item_t;

	typedef struct packed {
		logic [IDX_W-1:0] sample_index;
		logic [IDX_W-1:0] span;
		logic             overflow;
		logic             last_of_run;
	} out_item_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] value;
		logic [POS_W-1:0]        pos;
		logic                    last;
		logic                    ovf;
	} cmd_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] value;
		logic [IDX_W-1:0]        idx;
	} stack_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef enum logic {
		BK_RUN,
		BK_FLUSH
	} back_state_t;

endpackage

FILE: rtl/core/fsms_front.sv
// ----------------------------------------------------------------------------
// fsms_front: sample intake and classification
// Tracks the position within the sequence, flags samples past the length
// limit and hands one command per transaction to the queue.
// ----------------------------------------------------------------------------
module fsms_front import fsms_pkg::*; #(
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     sample_valid,
	output logic     sample_stall,
	input  in_item_t sample,
	input  q_stat_t  q_stat,
	output logic     q_push,
	output cmd_t     q_cmd
);

	localparam int CntW = $clog2(MAX_LEN + 1);

	logic [CntW-1:0] pos_q;
	logic            ovf;

	assign sample_stall = q_stat.full;
	assign q_push       = sample_valid && !q_stat.full;
	assign ovf          = (pos_q == CntW'(MAX_LEN));

	always_comb begin
		q_cmd.value = sample.sample_value;
		q_cmd.pos   = POS_W'(pos_q);
		q_cmd.last  = sample.last_sample;
		q_cmd.ovf   = ovf;
	end

	// restart on the final sample; hold at the limit once reached
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (q_push) begin
			if (sample.last_sample) begin
				pos_q <= '0;
			end else if (!ovf) begin
				pos_q <= pos_q + CntW'(1);
			end
		end
	end

endmodule

FILE: rtl/core/fsms_queue.sv
// ----------------------------------------------------------------------------
// fsms_queue: short command queue between front and back
// Small circular buffer; the head entry is visible while not empty.
// ----------------------------------------------------------------------------
module fsms_queue import fsms_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  cmd_t    push_cmd,
	input  logic    pop,
	output cmd_t    head,
	output q_stat_t q_stat
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	cmd_t            entry_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign head         = entry_q[rd_ptr_q];
	assign q_stat.full  = (count_q == CntW'(DEPTH));
	assign q_stat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + CntW'(1);
				2'b01:   count_q <= count_q - CntW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: rtl/core/fsms_back.sv
// ----------------------------------------------------------------------------
// fsms_back: stack engine and result output
// Pops smaller pending entries, pushes the new sample, flushes at the end of
// a sequence. One result is held back so the final one can be marked.
// ----------------------------------------------------------------------------
module fsms_back import fsms_pkg::*; #(
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cmd_t      head,
	input  q_stat_t   q_stat,
	output logic      deq,
	output logic      result_valid,
	input  logic      result_stall,
	output out_item_t result
);

	localparam int AddrW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int CntW  = $clog2(MAX_LEN + 1);

	stack_entry_t     mem [MAX_LEN];
	stack_entry_t     rd_q;
	stack_entry_t     byp_data_q;
	logic             byp_q;
	stack_entry_t     top;

	logic [CntW-1:0]  depth_q;
	logic [CntW-1:0]  depth_d;
	logic [CntW-1:0]  depth_m1;
	logic [AddrW-1:0] rd_addr;
	logic [AddrW-1:0] wr_addr;
	stack_entry_t     wr_data;

	back_state_t      state_q;
	back_state_t      state_d;

	logic             held_vld_q;
	out_item_t        held_q;
	logic             result_valid_q;
	out_item_t        result_q;

	logic             out_free;
	logic             have_top;
	logic             pop_hit;
	logic [POS_W-1:0] end_pos;
	logic [POS_W-1:0] base_pos;
	logic [IDX_W-1:0] span_val;

	logic             do_pop;
	logic             do_push;
	logic             new_res;
	logic             rel_held;
	logic             rel_last;
	logic             direct;

	assign top      = byp_q ? byp_data_q : rd_q;
	assign out_free = !result_valid_q || !result_stall;
	assign have_top = (depth_q != '0);
	assign pop_hit  = have_top && ($signed(top.value) < $signed(head.value));
	assign end_pos  = head.ovf ? POS_W'(MAX_LEN) : head.pos + POS_W'(1);
	assign base_pos = (state_q == BK_FLUSH) ? end_pos : head.pos;
	assign span_val = IDX_W'(base_pos - POS_W'(top.idx) - POS_W'(1));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_RUN: begin
				if (!q_stat.empty && head.last && (head.ovf || !pop_hit)) begin
					state_d = BK_FLUSH;
				end
			end
			BK_FLUSH: begin
				if (!have_top && out_free) begin
					state_d = BK_RUN;
				end
			end
		endcase
	end

	// per-cycle actions
	always_comb begin
		do_pop   = 1'b0;
		do_push  = 1'b0;
		deq      = 1'b0;
		new_res  = 1'b0;
		rel_held = 1'b0;
		rel_last = 1'b0;
		direct   = 1'b0;
		unique case (state_q)
			BK_RUN: begin
				if (!q_stat.empty) begin
					if (head.ovf) begin
						if (!head.last && out_free) begin
							direct = 1'b1;
							deq    = 1'b1;
						end
					end else if (pop_hit) begin
						if (!held_vld_q || out_free) begin
							do_pop   = 1'b1;
							new_res  = 1'b1;
							rel_held = held_vld_q;
						end
					end else if (head.last) begin
						do_push = 1'b1;
					end else if (!held_vld_q || out_free) begin
						do_push  = 1'b1;
						deq      = 1'b1;
						rel_held = held_vld_q;
						rel_last = 1'b1;
					end
				end
			end
			BK_FLUSH: begin
				if (have_top) begin
					if (!held_vld_q || out_free) begin
						do_pop   = 1'b1;
						new_res  = 1'b1;
						rel_held = held_vld_q;
					end
				end else if (out_free) begin
					deq      = 1'b1;
					rel_held = held_vld_q;
					rel_last = 1'b1;
					direct   = !held_vld_q;
				end
			end
		endcase
	end

	always_comb begin
		if (do_pop) begin
			depth_d = depth_q - CntW'(1);
		end else if (do_push) begin
			depth_d = depth_q + CntW'(1);
		end else begin
			depth_d = depth_q;
		end
	end

	assign depth_m1      = depth_d - CntW'(1);
	assign rd_addr       = depth_m1[AddrW-1:0];
	assign wr_addr       = depth_q[AddrW-1:0];
	assign wr_data.value = head.value;
	assign wr_data.idx   = head.pos[IDX_W-1:0];

	// stack memory: read the next top; a push lands on the read address
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q       <= mem[rd_addr];
		byp_data_q <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= BK_RUN;
			depth_q        <= '0;
			byp_q          <= 1'b0;
			held_vld_q     <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			depth_q <= depth_d;
			byp_q   <= do_push;
			if (new_res) begin
				held_vld_q <= 1'b1;
			end else if (rel_held) begin
				held_vld_q <= 1'b0;
			end
			if (rel_held || direct) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (new_res) begin
			held_q.sample_index <= top.idx;
			held_q.span         <= span_val;
			held_q.overflow     <= head.ovf;
			held_q.last_of_run  <= 1'b0;
		end
		if (rel_held) begin
			result_q.sample_index <= held_q.sample_index;
			result_q.span         <= held_q.span;
			result_q.overflow     <= held_q.overflow;
			result_q.last_of_run  <= rel_last;
		end else if (direct) begin
			result_q.sample_index <= '0;
			result_q.span         <= '0;
			result_q.overflow     <= 1'b1;
			result_q.last_of_run  <= 1'b1;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

FILE: rtl/core/forward_span_monotonic_stack.sv
// ----------------------------------------------------------------------------
// forward_span_monotonic_stack: forward span of a signed sample sequence
// Reports, for every sample, how many directly following samples are not
// greater than it, using a monotonic stack of pending samples.
// ----------------------------------------------------------------------------
// Samples enter one per transaction on the sample channel; results leave on
// the result channel, several per sample or none. A sample pops every pending
// entry with a strictly smaller value (one result each) and is then pushed;
// the sample marked last flushes all remaining entries with the span taken to
// the end of the sequence, and the next sample starts a new sequence at
// position 0. Samples beyond MAX_LEN are dropped and answered with overflow
// set (a dropped last sample still flushes, every flush result flagged). The
// final result of each sample carries last_of_run. The back engine handles a
// sample by popping each smaller entry in turn and then pushing it; a flush
// pops each remaining entry and then closes the sequence, and a dropped
// sample that is not last is answered directly. The back engine moves one
// stack entry per cycle while its output is not stalled, since the stack
// memory gives one registered read a cycle. The front accepts into a short
// command queue, so intake continues while the back engine works or its
// output is stalled, until the queue is full.
// ----------------------------------------------------------------------------
module forward_span_monotonic_stack import fsms_pkg::*; #(
	parameter int MAX_LEN     = MAX_LEN_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      sample_valid,
	output logic      sample_stall,
	input  in_item_t  sample,
	output logic      result_valid,
	input  logic      result_stall,
	output out_item_t result
);

	// front -> queue
	logic    q_push;
	cmd_t    q_cmd;
	// queue -> back
	cmd_t    q_head;
	q_stat_t q_stat;
	logic    q_deq;

	// classify each transaction and track the sequence position
	fsms_front #(
		.MAX_LEN (MAX_LEN)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.q_stat       (q_stat),
		.q_push       (q_push),
		.q_cmd        (q_cmd)
	);

	// decouple intake from the stack engine
	fsms_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_cmd),
		.pop      (q_deq),
		.head     (q_head),
		.q_stat   (q_stat)
	);

	// pop, push and flush the stack; drive results
	fsms_back #(
		.MAX_LEN (MAX_LEN)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (q_head),
		.q_stat       (q_stat),
		.deq          (q_deq),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

`ifndef NO_ASSERTIONS
	// the back engine never retires a command that is not there
	a_deq_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_deq |-> !q_stat.empty)
		else $error("command retired from an empty queue");

	// the front never writes into a full queue
	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_stat.full)
		else $error("command written into a full queue");

	// a reported span never reaches past the end of the sequence
	a_span_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |->
			(({1'b0, result.sample_index} + {1'b0, result.span}) < (IDX_W + 1)'(MAX_LEN)))
		else $error("span runs past the sequence length");
`endif

endmodule
